// File: rtl/core/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the load cell converter serial reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

    // conversion frame length in bits, MSB first
    localparam int DATA_BITS = 24;
    localparam int BIT_POS_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BIT_POS_W-1:0] FRAME_LEN = BIT_POS_W'(DATA_BITS);
    localparam logic [16:0] IDLE_SAT = 17'h1FFFF;
    localparam logic [7:0] RUN_SAT = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUIRED_LOW_POLLS     = 3'd0,
        CFG_MAX_IDLE_POLLS         = 3'd1,
        CFG_MAX_CONSECUTIVE_ERRORS = 3'd2,
        CFG_MAX_ONES_VALUE         = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  required_low_polls;
        logic [15:0] max_idle_polls;
        logic [7:0]  max_consecutive_errors;
        logic [31:0] max_ones_value;
    } t_cfg;

    typedef struct packed {
        logic        sclk_pulse;
        logic        reading_valid;
        logic [31:0] reading;
        logic        frame_error;
        logic        fatal;
        logic [31:0] reading_count;
        logic [31:0] error_count;
        logic [7:0]  consecutive_error_count;
    } t_result;

endpackage

// File: rtl/core/lcr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lcr_cfg_regs
// Configuration register file with reset defaults; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module lcr_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lcr_pkg::t_cfg                     o_cfg
);

    lcr_pkg::t_cfg r_cfg;
    lcr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcr_pkg::CFG_REQUIRED_LOW_POLLS:
                    n_cfg.required_low_polls = i_cfg_data[7:0];
                lcr_pkg::CFG_MAX_IDLE_POLLS:
                    n_cfg.max_idle_polls = i_cfg_data[15:0];
                lcr_pkg::CFG_MAX_CONSECUTIVE_ERRORS:
                    n_cfg.max_consecutive_errors = i_cfg_data[7:0];
                lcr_pkg::CFG_MAX_ONES_VALUE:
                    n_cfg.max_ones_value = i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.required_low_polls     <= 8'd3;
            r_cfg.max_idle_polls         <= 16'd1000;
            r_cfg.max_consecutive_errors <= 8'd10;
            r_cfg.max_ones_value         <= 32'd511;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/lcr_step.sv
// ----------------------------------------------------------------------------
// lcr_step
// Reader state and the single-pass update for one data line sample.
// ----------------------------------------------------------------------------
module lcr_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_level,
    input  lcr_pkg::t_cfg     i_cfg,
    output lcr_pkg::t_result  o_result
);

    logic                          r_shifting, n_shifting;
    logic [7:0]                    r_low_run, n_low_run;
    logic [16:0]                   r_idle_polls, n_idle_polls;
    logic [lcr_pkg::BIT_POS_W-1:0] r_bit_pos, n_bit_pos;
    logic [31:0]                   r_shift_value, n_shift_value;
    logic [31:0]                   r_last_value, n_last_value;
    logic [31:0]                   r_good_frames, n_good_frames;
    logic [31:0]                   r_bad_frames, n_bad_frames;
    logic [7:0]                    r_bad_run, n_bad_run;
    logic                          r_stopped, n_stopped;

    logic [7:0]                    low_inc;
    logic [16:0]                   idle_inc;
    logic [31:0]                   shifted;
    logic [lcr_pkg::BIT_POS_W-1:0] pos_inc;
    logic [31:0]                   ones_mask;
    logic [7:0]                    bad_inc;
    logic                          pulse, good, bad;

    assign shifted   = {r_shift_value[30:0], i_level};
    assign pos_inc   = r_bit_pos + 1'b1;
    assign ones_mask = shifted ^ (shifted + 32'd1);
    assign low_inc   = (r_low_run == lcr_pkg::RUN_SAT) ? r_low_run : r_low_run + 8'd1;
    assign idle_inc  = (r_idle_polls == lcr_pkg::IDLE_SAT) ? r_idle_polls
                                                            : r_idle_polls + 17'd1;
    assign bad_inc   = (r_bad_run == lcr_pkg::RUN_SAT) ? r_bad_run : r_bad_run + 8'd1;

    always_comb begin
        n_shifting    = r_shifting;
        n_low_run     = r_low_run;
        n_idle_polls  = r_idle_polls;
        n_bit_pos     = r_bit_pos;
        n_shift_value = r_shift_value;
        n_last_value  = r_last_value;
        n_good_frames = r_good_frames;
        n_bad_frames  = r_bad_frames;
        n_bad_run     = r_bad_run;
        n_stopped     = r_stopped;
        pulse         = 1'b0;
        good          = 1'b0;
        bad           = 1'b0;

        if (r_stopped) begin
            // stopped: hold everything
        end else if (!r_shifting) begin
            if (!i_level) begin
                n_low_run    = low_inc;
                n_idle_polls = '0;
            end else begin
                n_low_run    = '0;
                n_idle_polls = idle_inc;
            end
            // idle limit takes priority over the frame start
            if (n_idle_polls > {1'b0, i_cfg.max_idle_polls}) begin
                n_stopped = 1'b1;
            end else if (n_low_run >= i_cfg.required_low_polls) begin
                n_shifting    = 1'b1;
                n_bit_pos     = '0;
                n_shift_value = '0;
                pulse         = 1'b1;
            end
        end else begin
            n_shift_value = shifted;
            n_bit_pos     = pos_inc;
            if (pos_inc < lcr_pkg::FRAME_LEN) begin
                pulse = 1'b1;
            end else begin
                n_shifting   = 1'b0;
                n_low_run    = '0;
                n_idle_polls = '0;
                n_bit_pos    = '0;
                if (ones_mask > i_cfg.max_ones_value) begin
                    bad          = 1'b1;
                    n_bad_frames = r_bad_frames + 32'd1;
                    n_bad_run    = bad_inc;
                    if (bad_inc > i_cfg.max_consecutive_errors) begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    good          = 1'b1;
                    n_last_value  = shifted;
                    n_good_frames = r_good_frames + 32'd1;
                    n_bad_run     = '0;
                end
            end
        end
    end

    always_comb begin
        o_result.sclk_pulse              = pulse;
        o_result.reading_valid           = good;
        o_result.reading                 = n_last_value;
        o_result.frame_error             = bad;
        o_result.fatal                   = n_stopped;
        o_result.reading_count           = n_good_frames;
        o_result.error_count             = n_bad_frames;
        o_result.consecutive_error_count = n_bad_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifting    <= 1'b0;
            r_low_run     <= '0;
            r_idle_polls  <= '0;
            r_bit_pos     <= '0;
            r_shift_value <= '0;
            r_last_value  <= '0;
            r_good_frames <= '0;
            r_bad_frames  <= '0;
            r_bad_run     <= '0;
            r_stopped     <= 1'b0;
        end else if (i_fire) begin
            r_shifting    <= n_shifting;
            r_low_run     <= n_low_run;
            r_idle_polls  <= n_idle_polls;
            r_bit_pos     <= n_bit_pos;
            r_shift_value <= n_shift_value;
            r_last_value  <= n_last_value;
            r_good_frames <= n_good_frames;
            r_bad_frames  <= n_bad_frames;
            r_bad_run     <= n_bad_run;
            r_stopped     <= n_stopped;
        end
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stop flag cleared without reset");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_shifting |-> (r_bit_pos == '0))
        else $error("bit position nonzero while waiting");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos < lcr_pkg::FRAME_LEN)
        else $error("bit position beyond frame length");

endmodule

// File: rtl/core/lcr_out_stage.sv
// ----------------------------------------------------------------------------
// lcr_out_stage
// Result register: hold a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lcr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lcr_pkg::t_result  i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output lcr_pkg::t_result  o_result
);

    logic             r_valid;
    lcr_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/core/load_cell_adc_serial_reader_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_top
// Serial readout of a load cell converter: one data line sample in, one
// result out, with frame checking, counters and a sticky fatal flag.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | i_in_valid / o_in_stall   | i_data_level
//  out      | o_out_valid / i_out_stall | o_sclk_pulse .. o_consecutive_error_count
//  cfg      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One sample per cycle sustained while the output is not stalled; a result
//  reaches the output through the input register, then the result register.
//  All state updates happen in one pass of lcr_step as the sample moves from
//  the input register into the result register.
//  Synchronous active-low reset clears control state and restores the
//  configuration defaults.
//  A stall on the output holds the result register; the input register then
//  fills and o_in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transaction
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_data_level,
    // output transaction
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_sclk_pulse,
    output logic                           o_reading_valid,
    output logic [31:0]                    o_reading,
    output logic                           o_frame_error,
    output logic                           o_fatal,
    output logic [31:0]                    o_reading_count,
    output logic [31:0]                    o_error_count,
    output logic [7:0]                     o_consecutive_error_count,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lcr_pkg::t_cfg    cfg;
    lcr_pkg::t_result step_result;
    lcr_pkg::t_result out_result;

    logic r_in_valid;
    logic r_in_level;
    logic out_free;
    logic advance;
    logic in_accept;

    // Advance the held sample whenever the result register can take it.
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the sample; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_level <= i_data_level;
        end
    end

    lcr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcr_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    lcr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    // Unpack the result register onto the ports.
    assign o_sclk_pulse              = out_result.sclk_pulse;
    assign o_reading_valid           = out_result.reading_valid;
    assign o_reading                 = out_result.reading;
    assign o_frame_error             = out_result.frame_error;
    assign o_fatal                   = out_result.fatal;
    assign o_reading_count           = out_result.reading_count;
    assign o_error_count             = out_result.error_count;
    assign o_consecutive_error_count = out_result.consecutive_error_count;

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced sample did not reach the result register");

    a_verdict_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reading_valid && o_frame_error)
                     && !(o_sclk_pulse && (o_reading_valid || o_frame_error)))
        else $error("conflicting frame verdict flags");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

endmodule
